@@ rtl/cc20_pkg.sv @@
// shared types, constants and codes for the chacha20 stream cipher
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_status_t;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	// rotate amount select of the mixing unit
	localparam logic [1:0] ROT_16 = 2'd0;
	localparam logic [1:0] ROT_12 = 2'd1;
	localparam logic [1:0] ROT_8  = 2'd2;
	localparam logic [1:0] ROT_7  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_KEY01   = 3'd0;
	localparam logic [2:0] REG_KEY23   = 3'd1;
	localparam logic [2:0] REG_KEY45   = 3'd2;
	localparam logic [2:0] REG_KEY67   = 3'd3;
	localparam logic [2:0] REG_NONCE01 = 3'd4;
	localparam logic [2:0] REG_NONCE2  = 3'd5;
	localparam logic [2:0] REG_INITCTR = 3'd6;
	localparam logic [2:0] REG_ROUNDS  = 3'd7;

	localparam logic [4:0] ROUNDS_RESET = 5'd20;

endpackage

@@ rtl/cc20_alu.sv @@
// shared add, xor and rotate unit for quarter-round steps and feed-forward
module cc20_alu (
	input  cc20_pkg::word_t x,
	input  cc20_pkg::word_t y,
	input  cc20_pkg::word_t z,
	input  logic [1:0]      rot_sel,
	output cc20_pkg::word_t sum,
	output cc20_pkg::word_t mix
);
	import cc20_pkg::*;

	word_t t;

	assign sum = x + y;
	assign t   = z ^ sum;

	always_comb begin
		unique case (rot_sel)
			ROT_16:  mix = {t[15:0], t[31:16]};
			ROT_12:  mix = {t[19:0], t[31:20]};
			ROT_8:   mix = {t[23:0], t[31:24]};
			ROT_7:   mix = {t[24:0], t[31:25]};
			default: mix = t;
		endcase
	end

endmodule

@@ rtl/cc20_core.sv @@
// block generator: working state, round sequencer and keystream registers
module cc20_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   gen_req,
	input  logic [4:0]             doubles,
	input  cc20_pkg::block_t       init_words,
	output cc20_pkg::block_t       keystream,
	output cc20_pkg::core_status_t status
);
	import cc20_pkg::*;

	localparam logic [1:0] C_IDLE  = 2'd0;
	localparam logic [1:0] C_ROUND = 2'd1;
	localparam logic [1:0] C_FEED  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] step_q;
	logic [2:0] qr_q;
	logic [4:0] dr_q;
	logic [3:0] fidx_q;
	logic       done_q;
	block_t     w_q;
	block_t     ks_q;

	word_t      alu_x, alu_y, alu_z, alu_sum, alu_mix;
	logic [1:0] rot_sel;
	block_t     upd, rot, w_nxt;
	logic [3:0][1:0] amt;

	cc20_alu u_alu (
		.x      (alu_x),
		.y      (alu_y),
		.z      (alu_z),
		.rot_sel(rot_sel),
		.sum    (alu_sum),
		.mix    (alu_mix)
	);

	// state sits as a 4x4 matrix; quarter rounds always work on column 0
	always_comb begin
		if (state_q == C_FEED) begin
			alu_x = w_q[fidx_q];
			alu_y = init_words[fidx_q];
			alu_z = '0;
		end else if (!step_q[0]) begin
			alu_x = w_q[0];
			alu_y = w_q[4];
			alu_z = w_q[12];
		end else begin
			alu_x = w_q[8];
			alu_y = w_q[12];
			alu_z = w_q[4];
		end
		unique case (step_q)
			2'd0:    rot_sel = ROT_16;
			2'd1:    rot_sel = ROT_12;
			2'd2:    rot_sel = ROT_8;
			default: rot_sel = ROT_7;
		endcase
	end

	always_comb begin
		upd = w_q;
		if (!step_q[0]) begin
			upd[0]  = alu_sum;
			upd[12] = alu_mix;
		end else begin
			upd[8] = alu_sum;
			upd[4] = alu_mix;
		end
		// rows shift left after each quarter round; extra shift diagonalizes and undoes it
		for (int k = 0; k < 4; k++) begin
			if (qr_q == 3'd3)
				amt[k] = 2'(k + 1);
			else if (qr_q == 3'd7)
				amt[k] = 2'(1 - k);
			else
				amt[k] = 2'd1;
		end
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++) begin
				rot[4*k+j] = upd[{2'(k), 2'(2'(j) + amt[k])}];
			end
		end
		w_nxt = (step_q == 2'd3) ? rot : upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			qr_q    <= '0;
			dr_q    <= '0;
			fidx_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == C_FEED) && (fidx_q == 4'd15);
			unique case (state_q)
				C_IDLE: begin
					if (gen_req) begin
						step_q  <= '0;
						qr_q    <= '0;
						dr_q    <= '0;
						fidx_q  <= '0;
						state_q <= (doubles == 5'd0) ? C_FEED : C_ROUND;
					end
				end
				C_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						qr_q <= qr_q + 3'd1;
						if (qr_q == 3'd7) begin
							dr_q <= dr_q + 5'd1;
							if (5'(dr_q + 5'd1) == doubles)
								state_q <= C_FEED;
						end
					end
				end
				C_FEED: begin
					fidx_q <= fidx_q + 4'd1;
					if (fidx_q == 4'd15)
						state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && gen_req)
			w_q <= init_words;
		else if (state_q == C_ROUND)
			w_q <= w_nxt;
		if (state_q == C_FEED)
			ks_q[fidx_q] <= alu_sum;
	end

	assign keystream   = ks_q;
	assign status.busy = (state_q != C_IDLE);
	assign status.done = done_q;

endmodule

@@ rtl/chacha20_stream_cipher_top.sv @@
// chacha20 stream cipher top: config registers, byte stream handshake, keystream select
// a word whose keystream block is ready is XORed and registered to the output as it is taken
// a word that opens a block (start flag, position wraps, or no block yet) waits for block
//   generation: D = (round_count + 1) / 2 double rounds, the feed-forward of all 16 words,
//   then the handoff through the core done flag and the out state, which registers it once the output is free
// sustained: one word per cycle inside a block while the receiver takes each word; arst_n clears
// control state, registers and the counter, round_count resets to 20
module chacha20_stream_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] start_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cc20_pkg::*;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_GEN  = 2'd1;
	localparam logic [1:0] T_OUT  = 2'd2;

	logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
	word_t       nonce2_q, init_ctr_q, ctr_q;
	logic [4:0]  rounds_q;
	logic [5:0]  pos_q;
	logic        blk_ready_q;
	logic [1:0]  state_q;
	logic [7:0]  pend_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;

	logic         out_free, in_acc, start, need_gen, gen_req, emit;
	logic [4:0]   doubles;
	block_t       init_words, keystream;
	core_status_t core_st;
	word_t        ks_word, ks_shift;
	logic [7:0]   ks_byte, emit_data;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == T_IDLE) && out_free && !core_st.busy;
	assign in_acc    = s_tvalid && s_tready;
	assign start     = s_tuser[0];
	assign need_gen  = start || !blk_ready_q;
	assign gen_req   = in_acc && need_gen;
	assign doubles   = 5'((6'(rounds_q) + 6'd1) >> 1);

	always_comb begin
		init_words[0]  = SIGMA0;
		init_words[1]  = SIGMA1;
		init_words[2]  = SIGMA2;
		init_words[3]  = SIGMA3;
		init_words[4]  = key01_q[31:0];
		init_words[5]  = key01_q[63:32];
		init_words[6]  = key23_q[31:0];
		init_words[7]  = key23_q[63:32];
		init_words[8]  = key45_q[31:0];
		init_words[9]  = key45_q[63:32];
		init_words[10] = key67_q[31:0];
		init_words[11] = key67_q[63:32];
		// a restart loads the counter on the same edge the core samples it
		init_words[12] = (in_acc && start) ? init_ctr_q : ctr_q;
		init_words[13] = nonce01_q[31:0];
		init_words[14] = nonce01_q[63:32];
		init_words[15] = nonce2_q;
	end

	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.gen_req   (gen_req),
		.doubles   (doubles),
		.init_words(init_words),
		.keystream (keystream),
		.status    (core_st)
	);

	assign ks_word   = keystream[pos_q[5:2]];
	assign ks_shift  = ks_word >> {pos_q[1:0], 3'b000};
	assign ks_byte   = ks_shift[7:0];
	assign emit      = (state_q == T_IDLE) ? (in_acc && !need_gen)
	                                       : (state_q == T_OUT && out_free);
	assign emit_data = ((state_q == T_IDLE) ? s_tdata : pend_q) ^ ks_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q     <= '0;
			key23_q     <= '0;
			key45_q     <= '0;
			key67_q     <= '0;
			nonce01_q   <= '0;
			nonce2_q    <= '0;
			init_ctr_q  <= '0;
			rounds_q    <= ROUNDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY01:   key01_q    <= cfg_data;
				REG_KEY23:   key23_q    <= cfg_data;
				REG_KEY45:   key45_q    <= cfg_data;
				REG_KEY67:   key67_q    <= cfg_data;
				REG_NONCE01: nonce01_q  <= cfg_data;
				REG_NONCE2:  nonce2_q   <= cfg_data[31:0];
				REG_INITCTR: init_ctr_q <= cfg_data[31:0];
				REG_ROUNDS:  rounds_q   <= cfg_data[4:0];
				default:     rounds_q   <= rounds_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			ctr_q       <= '0;
			pos_q       <= '0;
			blk_ready_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (gen_req) begin
						state_q     <= T_GEN;
						blk_ready_q <= 1'b0;
						if (start) begin
							ctr_q <= init_ctr_q;
							pos_q <= '0;
						end
					end
				end
				T_GEN: begin
					if (core_st.done) begin
						blk_ready_q <= 1'b1;
						state_q     <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free)
						state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
			if (emit) begin
				pos_q <= pos_q + 6'd1;
				// last byte of the block: next byte needs a fresh block
				if (pos_q == 6'd63) begin
					ctr_q       <= ctr_q + 32'd1;
					blk_ready_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_req)
			pend_q <= s_tdata;
		if (emit)
			m_tdata_q <= emit_data;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/cc20_checker.sv @@
// port-level checks for the chacha20 stream cipher top
module cc20_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	logic in_acc, out_acc;
	logic pend_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// one word in flight at most
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else if (in_acc)
			pend_q <= 1'b1;
		else if (out_acc)
			pend_q <= 1'b0;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !pend_q || out_acc)
		else $error("input word taken while a result is still owed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q)
		else $error("output word without a matching input word");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

@@ tb/sv/chacha20_stream_cipher_top_test.sv @@
// self-checking testbench for the chacha20 byte stream cipher top
module chacha20_stream_cipher_top_test;

	localparam logic [31:0] EXPAND_0 = 32'h61707865;
	localparam logic [31:0] EXPAND_1 = 32'h3320646e;
	localparam logic [31:0] EXPAND_2 = 32'h79622d32;
	localparam logic [31:0] EXPAND_3 = 32'h6b206574;
	// longest block generation is 16 double rounds, and the settle wait is sized for it
	localparam int GEN_SETTLE = 600;
	localparam int CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	chacha20_stream_cipher_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// cipher state mirrored from the block
	logic [63:0] key01, key23, key45, key67, nonce01;
	logic [31:0] nonce2, init_ctr, blk_ctr;
	logic [4:0]  rounds;
	logic [31:0] ks_words [16];
	logic [31:0] mix_w [16];
	logic [5:0]  byte_pos;
	bit          ks_valid;

	logic [7:0] expected_bytes [$];
	int errors = 0;
	int cycles = 0;
	int rx_hold = 0;
	bit quiet = 0;

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void quarter(int a, int b, int c, int d);
		mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
		mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
		mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
		mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
	endfunction

	function automatic void build_keystream();
		logic [31:0] start_w [16];
		int n_double;
		start_w[0] = EXPAND_0;
		start_w[1] = EXPAND_1;
		start_w[2] = EXPAND_2;
		start_w[3] = EXPAND_3;
		start_w[4] = key01[31:0];
		start_w[5] = key01[63:32];
		start_w[6] = key23[31:0];
		start_w[7] = key23[63:32];
		start_w[8] = key45[31:0];
		start_w[9] = key45[63:32];
		start_w[10] = key67[31:0];
		start_w[11] = key67[63:32];
		start_w[12] = blk_ctr;
		start_w[13] = nonce01[31:0];
		start_w[14] = nonce01[63:32];
		start_w[15] = nonce2;
		// one double round per started pair, so odd counts round up
		n_double = (int'(rounds) + 1) / 2;
		for (int i = 0; i < 16; i++)
			mix_w[i] = start_w[i];
		for (int r = 0; r < n_double; r++) begin
			quarter(0, 4, 8, 12);
			quarter(1, 5, 9, 13);
			quarter(2, 6, 10, 14);
			quarter(3, 7, 11, 15);
			quarter(0, 5, 10, 15);
			quarter(1, 6, 11, 12);
			quarter(2, 7, 8, 13);
			quarter(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			ks_words[i] = mix_w[i] + start_w[i];
	endfunction

	function automatic logic [7:0] cipher_byte(logic [7:0] data, logic start);
		logic [31:0] w;
		if (start) begin
			blk_ctr = init_ctr;
			byte_pos = '0;
			ks_valid = 0;
		end
		if (!ks_valid) begin
			build_keystream();
			ks_valid = 1;
		end
		w = ks_words[byte_pos[5:2]];
		cipher_byte = data ^ 8'(w >> {byte_pos[1:0], 3'b000});
		byte_pos = byte_pos + 6'd1;
		// counter wraps silently past all ones
		if (byte_pos == 6'd0) begin
			blk_ctr = blk_ctr + 32'd1;
			ks_valid = 0;
		end
	endfunction

	function automatic void set_reg(logic [2:0] idx, logic [63:0] value);
		case (idx)
			cc20_pkg::REG_KEY01: key01 = value;
			cc20_pkg::REG_KEY23: key23 = value;
			cc20_pkg::REG_KEY45: key45 = value;
			cc20_pkg::REG_KEY67: key67 = value;
			cc20_pkg::REG_NONCE01: nonce01 = value;
			cc20_pkg::REG_NONCE2: nonce2 = value[31:0];
			cc20_pkg::REG_INITCTR: init_ctr = value[31:0];
			cc20_pkg::REG_ROUNDS: rounds = value[4:0];
			default: ;
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, a long hold-off on request, none at the tail
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// output word checker
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, want, m_tdata);
					errors++;
				end
			end
		end
	end

	// entered and left at a falling edge; valid stays up for the next word
	task automatic send_byte(input logic [7:0] data, input logic start);
		logic [7:0] exp_byte;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		exp_byte = cipher_byte(data, start);
		expected_bytes = {expected_bytes, exp_byte};
		@(negedge clk);
	endtask

	task automatic send_stream(input int count, input bit open_msg, input int start_odds);
		for (int k = 0; k < count; k++)
			send_byte(8'($urandom()), (k == 0 && open_msg) ||
				(start_odds > 0 && $urandom_range(1, start_odds) == 1));
	endtask

	// wait out every result and any block generation still running
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (GEN_SETTLE) @(negedge clk);
	endtask

	task automatic load_config(input logic [63:0] k01, k23, k45, k67, n01,
			input logic [31:0] n2, ctr, input logic [63:0] rnd);
		logic [63:0] vals [8];
		vals[cc20_pkg::REG_KEY01] = k01;
		vals[cc20_pkg::REG_KEY23] = k23;
		vals[cc20_pkg::REG_KEY45] = k45;
		vals[cc20_pkg::REG_KEY67] = k67;
		vals[cc20_pkg::REG_NONCE01] = n01;
		vals[cc20_pkg::REG_NONCE2] = {32'd0, n2};
		vals[cc20_pkg::REG_INITCTR] = {32'd0, ctr};
		vals[cc20_pkg::REG_ROUNDS] = rnd;
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			set_reg(3'(i), vals[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random_config(input logic [31:0] ctr, input logic [63:0] rnd);
		load_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(), ctr, rnd);
	endtask

	// default registers, stream opens from counter zero without a start flag, then restarts with one
	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(8'ha5, 1'b1);
		drain();
	endtask

	task automatic test_extreme_config();
		load_config('1, '1, '1, '1, '1, '1, '1, 64'd31);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'h7e, 1'b1);
		send_byte(8'h01, 1'b0);
		drain();
		// zero rounds leaves just the doubled input words
		load_config('0, '0, '0, '0, '0, '0, '0, 64'd0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h3c, 1'b1);
		drain();
		// upper data bits of the round register are dropped; odd count
		load_random_config($urandom(), 64'hffff_ffff_ffff_ffe3);
		send_byte(8'hc3, 1'b1);
		send_byte(8'h18, 1'b1);
		send_byte(8'he7, 1'b1);
		drain();
		load_random_config($urandom(), 64'd2);
		send_stream(3, 1, 0);
		drain();
		load_random_config($urandom(), 64'd20);
		send_stream(3, 1, 0);
		drain();
	endtask

	// all-ones counter rolls over to zero across the block boundary
	task automatic test_counter_wrap();
		load_random_config(32'hffff_ffff, 64'd8);
		send_stream(130, 1, 0);
		drain();
	endtask

	task automatic test_random_streams();
		logic [63:0] rnd;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: rnd = 64'd20;
				1: rnd = 64'd2;
				default: rnd = rand64();
			endcase
			load_random_config($urandom(), rnd);
			send_stream(45, 1'($urandom_range(0, 1)), 32);
			drain();
		end
	endtask

	// receiver holds off while the sender keeps pushing, so the input backs up
	task automatic test_backpressure();
		load_random_config($urandom(), 64'($urandom_range(2, 12)));
		rx_hold = 300;
		send_stream(80, 1, 40);
		drain();
	endtask

	task automatic test_quiet_tail();
		quiet = 1;
		load_random_config($urandom(), 64'd20);
		send_stream(50, 1, 0);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		key01 = '0;
		key23 = '0;
		key45 = '0;
		key67 = '0;
		nonce01 = '0;
		nonce2 = '0;
		init_ctr = '0;
		rounds = cc20_pkg::ROUNDS_RESET;
		blk_ctr = '0;
		byte_pos = '0;
		ks_valid = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_extreme_config();
		test_counter_wrap();
		test_random_streams();
		test_backpressure();
		test_quiet_tail();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
